### sv/depth_hole_fill_3x3_top_macros.svh
// Assertion macros shared by the depth hole filler.
`ifndef DEPTH_HOLE_FILL_3X3_TOP_MACROS_SVH
`define DEPTH_HOLE_FILL_3X3_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DHF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dhf_pkg.sv
// Package with shared constants, types and the reciprocal table of the depth hole filler.
`timescale 1ns / 1ps

package dhf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 11;
  localparam int PIX_W      = 16;
  localparam int IDX_W      = 21;
  localparam int ROW_CAP    = MAX_HEIGHT + 2;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic accept;
    logic load;
    logic sum1;
    logic sum2;
    logic mul;
    logic fix;
  } dhf_cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
  } dhf_sts_t;

  // Floor of 2^20 divided by the neighbor count.
  function automatic logic [20:0] recip(input logic [3:0] cnt);
    logic [20:0] r;
    case (cnt)
      4'd1: r = 21'd1048576;
      4'd2: r = 21'd524288;
      4'd3: r = 21'd349525;
      4'd4: r = 21'd262144;
      4'd5: r = 21'd209715;
      4'd6: r = 21'd174762;
      4'd7: r = 21'd149796;
      4'd8: r = 21'd131072;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/dhf_ctrl.sv
// Controller state machine that sequences one word through the datapath.
`timescale 1ns / 1ps

module dhf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dhf_pkg::dhf_sts_t sts,
  output dhf_pkg::dhf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SUM1 = 3'd2;
  localparam logic [2:0] S_SUM2 = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.load   = (state == S_LOAD);
    cmd.sum1   = (state == S_SUM1);
    cmd.sum2   = (state == S_SUM2);
    cmd.mul    = (state == S_MUL);
    cmd.fix    = (state == S_FIX);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !sts.drop) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = sts.emit ? S_SUM1 : S_IDLE;
      end
      S_SUM1: state_next = S_SUM2;
      S_SUM2: state_next = S_MUL;
      S_MUL:  state_next = S_FIX;
      S_FIX:  state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/dhf_datapath.sv
// Datapath with line stores, 3x3 window, position counters and neighbor mean unit.
`timescale 1ns / 1ps

module dhf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dhf_pkg::dhf_cmd_t             cmd,
  output dhf_pkg::dhf_sts_t             sts,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dhf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          op,
  input  logic [dhf_pkg::PIX_W-1:0]     depth_in,
  output logic [dhf_pkg::PIX_W-1:0]     depth_out,
  output logic                          frame_last
);

  logic [dhf_pkg::CFG_W-1:0] width;
  logic [dhf_pkg::CFG_W-1:0] height;
  logic [dhf_pkg::IDX_W-1:0] frame_size;
  logic [dhf_pkg::COL_W-1:0] col;
  logic [dhf_pkg::CFG_W-1:0] row;
  logic [dhf_pkg::IDX_W-1:0] idx;

  logic [dhf_pkg::PIX_W-1:0] mem_up  [dhf_pkg::MAX_WIDTH];
  logic [dhf_pkg::PIX_W-1:0] mem_mid [dhf_pkg::MAX_WIDTH];
  logic [dhf_pkg::PIX_W-1:0] up_rd;
  logic [dhf_pkg::PIX_W-1:0] mid_rd;
  logic [dhf_pkg::PIX_W-1:0] val_q;
  logic [dhf_pkg::PIX_W-1:0] win [3][3];

  logic [dhf_pkg::PIX_W-1:0] nb_q [8];
  logic [dhf_pkg::PIX_W-1:0] centre_q;
  logic [3:0]                cnt_q;
  logic [16:0]               pair_q [4];
  logic [18:0]               sum_q;
  logic [dhf_pkg::PIX_W-1:0] q0_q;

  logic [dhf_pkg::COL_W-1:0] c_eff;
  logic                      c_zero;
  logic                      pixels_done;
  logic                      left_ok;
  logic                      right_ok;
  logic                      top_ok;
  logic                      bottom_ok;
  logic [dhf_pkg::PIX_W-1:0] nb_val [8];
  logic [7:0]                nb_en;
  logic [7:0]                nb_nz;
  logic [3:0]                cnt_next;
  logic [dhf_pkg::CFG_W-1:0] col_inc;
  logic [dhf_pkg::IDX_W-1:0] idx_inc;
  logic                      last;
  logic [dhf_pkg::CFG_W-1:0] cfg_limit;
  logic [dhf_pkg::CFG_W-1:0] cfg_clamped;
  logic [39:0]               prod;
  logic [19:0]               back;
  logic [19:0]               rem;
  logic [dhf_pkg::PIX_W-1:0] quot;

  always_comb begin
    c_eff       = ({1'b0, col} >= width) ? '0 : col;
    c_zero      = (c_eff == '0);
    pixels_done = (row >= height);
    sts.drop    = (op == dhf_pkg::OP_FLUSH) && !pixels_done;
    sts.emit    = (row >= 11'd2) || ((row == 11'd1) && !c_zero);
    left_ok     = c_zero ? (width >= 11'd2) : (c_eff >= 10'd2);
    right_ok    = !c_zero;
    top_ok      = c_zero ? (row >= 11'd3) : (row >= 11'd2);
    bottom_ok   = c_zero ? (row <= height) : (row < height);
    col_inc     = {1'b0, c_eff} + 11'd1;
    idx_inc     = idx + 21'd1;
    last        = (idx_inc >= frame_size);
  end

  always_comb begin
    nb_val[0] = win[0][1];  nb_en[0] = top_ok && left_ok;
    nb_val[1] = win[1][1];  nb_en[1] = left_ok;
    nb_val[2] = win[2][1];  nb_en[2] = bottom_ok && left_ok;
    nb_val[3] = win[0][2];  nb_en[3] = top_ok;
    nb_val[4] = win[2][2];  nb_en[4] = bottom_ok;
    nb_val[5] = up_rd;      nb_en[5] = top_ok && right_ok;
    nb_val[6] = mid_rd;     nb_en[6] = right_ok;
    nb_val[7] = val_q;      nb_en[7] = bottom_ok && right_ok;
    cnt_next = '0;
    for (int i = 0; i < 8; i++) begin
      nb_nz[i] = nb_en[i] && (nb_val[i] != '0);
      cnt_next = cnt_next + {3'b0, nb_nz[i]};
    end
  end

  always_comb begin
    cfg_limit = (cfg_index == dhf_pkg::REG_FRAME_WIDTH) ? 11'(dhf_pkg::MAX_WIDTH) :
                                                          11'(dhf_pkg::MAX_HEIGHT);
    if (cfg_data == '0) begin
      cfg_clamped = 11'd1;
    end else if (cfg_data > cfg_limit) begin
      cfg_clamped = cfg_limit;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      up_rd <= mem_up[c_eff];
    end
    if (cmd.load) begin
      mem_up[c_eff] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mid_rd <= mem_mid[c_eff];
    end
    if (cmd.load) begin
      mem_mid[c_eff] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    frame_size <= {10'b0, width} * {10'b0, height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= 11'd640;
      height <= 11'd480;
      col    <= '0;
      row    <= '0;
      idx    <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cfg_we) begin
      if (cfg_index == dhf_pkg::REG_FRAME_WIDTH) begin
        width <= cfg_clamped;
      end else begin
        height <= cfg_clamped;
      end
      col <= '0;
      row <= '0;
      idx <= '0;
    end else if (cmd.load) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_rd;
      win[1][2] <= mid_rd;
      win[2][2] <= val_q;
      if (sts.emit && last) begin
        col <= '0;
        row <= '0;
        idx <= '0;
      end else begin
        if (col_inc >= width) begin
          col <= '0;
          if (row < 11'(dhf_pkg::ROW_CAP)) begin
            row <= row + 11'd1;
          end
        end else begin
          col <= col_inc[dhf_pkg::COL_W-1:0];
        end
        if (sts.emit) begin
          idx <= idx_inc;
        end
      end
    end
  end

  always_comb begin
    prod = 40'(sum_q) * 40'(dhf_pkg::recip(cnt_q));
    back = 20'(q0_q) * 20'(cnt_q);
    rem  = 20'(sum_q) - back;
    quot = (rem >= 20'(cnt_q)) ? q0_q + 16'd1 : q0_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_q <= pixels_done ? '0 : depth_in;
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        nb_q[i] <= nb_nz[i] ? nb_val[i] : '0;
      end
      centre_q   <= win[1][2];
      cnt_q      <= cnt_next;
      frame_last <= last;
    end
    if (cmd.sum1) begin
      for (int i = 0; i < 4; i++) begin
        pair_q[i] <= {1'b0, nb_q[2*i]} + {1'b0, nb_q[2*i+1]};
      end
    end
    if (cmd.sum2) begin
      sum_q <= ({2'b0, pair_q[0]} + {2'b0, pair_q[1]}) +
               ({2'b0, pair_q[2]} + {2'b0, pair_q[3]});
    end
    if (cmd.mul) begin
      q0_q <= prod[35:20];
    end
    if (cmd.fix) begin
      if (centre_q != '0) begin
        depth_out <= centre_q;
      end else if (cnt_q == '0) begin
        depth_out <= '0;
      end else begin
        depth_out <= quot;
      end
    end
  end

endmodule

### sv/depth_hole_fill_3x3_top.sv
// Top level of the 3x3 depth hole filler: controller, datapath and checks.
// A word with a result passes LOAD, SUM1, SUM2, MUL and FIX before raising out_valid.
// Only idle takes input; a word without a result returns from LOAD, an ignored flush stays.
// The latency is set by the line store read, a two-step adder tree and the reciprocal divide.
// Reset clears position counters and the 3x3 window and sets the frame to 640 x 480.
// Line stores are not cleared; unwritten entries only feed pixels outside the image.
`timescale 1ns / 1ps
`include "depth_hole_fill_3x3_top_macros.svh"

module depth_hole_fill_3x3_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [dhf_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [dhf_pkg::PIX_W-1:0] depth_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dhf_pkg::PIX_W-1:0] depth_out,
  output logic                      frame_last
);

  dhf_pkg::dhf_cmd_t cmd;
  dhf_pkg::dhf_sts_t sts;

  dhf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dhf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .depth_in   (depth_in),
    .depth_out  (depth_out),
    .frame_last (frame_last)
  );

  `DHF_ASSERT_SAME(a_one_word_at_a_time, out_valid, !in_ready, "input taken while a result waits")
  `DHF_ASSERT_NEXT(a_back_to_idle, out_valid && out_ready, in_ready, "not idle after result taken")
  `DHF_ASSERT_NEXT(a_word_starts, in_valid && in_ready && !sts.drop, cmd.load, "accepted word not loaded")
  `DHF_ASSERT_NEXT(a_drop_stays_idle, in_valid && in_ready && sts.drop, in_ready, "ignored flush left idle")

endmodule
